@@ design/tcfe_pkg.sv @@
// Shared types, constants and trig table builders for the timestamp feature encoder.
package tcfe_pkg;

  localparam int OutFracBits = 14;
  localparam int FeatWidth = 16;
  localparam int SecWidth = 39;
  localparam int MeanWidth = 22;
  localparam int InvStdWidth = 24;
  localparam int YearFrac = 24;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth = 24;

  localparam logic [CfgIndexWidth-1:0] RegYearMean = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] RegYearInvStd = CfgIndexWidth'(1);

  localparam logic [MeanWidth-1:0] YearMeanReset = MeanWidth'(512000);
  localparam logic [InvStdWidth-1:0] YearInvStdReset = InvStdWidth'(65536);

  typedef logic signed [FeatWidth-1:0] feat_t;
  typedef logic signed [15:0] year_t;

  typedef struct packed {
    year_t      year;
    logic [3:0] month;
    logic [4:0] day;
    logic       missing;
  } date_t;

  typedef logic [15:0][FeatWidth-1:0] month_tab_t;
  typedef logic [31:0][FeatWidth-1:0] day_tab_t;

  localparam longint Months = 12;
  localparam longint Days = 31;
  localparam longint Q30One = 64'sd1073741824;
  localparam longint Q30Half = 64'sd536870912;
  localparam longint Q30HalfPi = 64'sd1686629713;
  localparam longint TaylorSinDiv [8] = '{6, 20, 42, 72, 110, 156, 210, 272};
  localparam longint TaylorCosDiv [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

  // sin or cos in Q30 of x (Q30 radians, 0..pi/4), nine series terms
  function automatic longint taylor_q30(input longint x, input bit want_cos);
    longint x2, ts, tc, ss, cc;
    x2 = (x * x + Q30Half) >>> 30;
    ts = x;
    tc = Q30One;
    ss = x;
    cc = Q30One;
    for (int i = 0; i < 8; i++) begin
      ts = ((ts * x2 + Q30Half) >>> 30) / TaylorSinDiv[i];
      tc = ((tc * x2 + Q30Half) >>> 30) / TaylorCosDiv[i];
      if ((i & 1) == 0) begin
        ss = ss - ts;
        cc = cc - tc;
      end else begin
        ss = ss + ts;
        cc = cc + tc;
      end
    end
    return want_cos ? cc : ss;
  endfunction

  // octant swap and quadrant rotation of the reduced angle
  function automatic longint trig_pick(input longint q, input longint x, input bit swap,
                                       input bit want_cos);
    longint ps, pc, tmp, s, c;
    ps = taylor_q30(x, 1'b0);
    pc = taylor_q30(x, 1'b1);
    if (swap) begin
      tmp = ps;
      ps = pc;
      pc = tmp;
    end
    unique case (q[1:0])
      2'd0: begin s = ps;  c = pc;  end
      2'd1: begin s = pc;  c = -ps; end
      2'd2: begin s = -ps; c = -pc; end
      2'd3: begin s = -pc; c = ps;  end
    endcase
    return want_cos ? c : s;
  endfunction

  function automatic longint month_q30(input longint k, input bit want_cos);
    longint kk, q, rem, x;
    bit swap;
    kk = ((k % Months) + Months) % Months;
    q = (4 * kk) / Months;
    rem = 4 * kk - q * Months;
    swap = (2 * rem > Months);
    if (swap) x = (Q30HalfPi * (Months - rem) + Months / 2) / Months;
    else x = (Q30HalfPi * rem + Months / 2) / Months;
    return trig_pick(q, x, swap, want_cos);
  endfunction

  function automatic longint day_q30(input longint k, input bit want_cos);
    longint kk, q, rem, x;
    bit swap;
    kk = ((k % Days) + Days) % Days;
    q = (4 * kk) / Days;
    rem = 4 * kk - q * Days;
    swap = (2 * rem > Days);
    if (swap) x = (Q30HalfPi * (Days - rem) + Days / 2) / Days;
    else x = (Q30HalfPi * rem + Days / 2) / Days;
    return trig_pick(q, x, swap, want_cos);
  endfunction

  // Q30 to output format: round half away from zero, then saturate
  function automatic feat_t to_out_q30(input longint v, input int frac);
    longint r, mag;
    int s;
    s = 30 - frac;
    if (s <= 0) begin
      r = v;
    end else begin
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
      r = (v < 0) ? -mag : mag;
    end
    if (r < -32768) r = -32768;
    if (r > 32767) r = 32767;
    return feat_t'(r);
  endfunction

  // indexed by month number; 12 wraps to 0
  function automatic month_tab_t month_tab(input int frac, input bit want_cos);
    month_tab_t t;
    for (int k = 0; k < 16; k++) t[k] = to_out_q30(month_q30(longint'(k), want_cos), frac);
    return t;
  endfunction

  // indexed by day of month; 31 wraps to 0
  function automatic day_tab_t day_tab(input int frac, input bit want_cos);
    day_tab_t t;
    for (int k = 0; k < 32; k++) t[k] = to_out_q30(day_q30(longint'(k), want_cos), frac);
    return t;
  endfunction

endpackage

@@ design/timestamp_cyclic_feature_encoder.sv @@
// Cyclic date feature encoder: Unix seconds in, five fixed-point features out.
//
// Input channel: in_valid / in_stall with unix_seconds (signed 39-bit) and
// is_missing. A word is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with month_sine, month_cosine, day_sine,
// day_cosine and year_normalized, signed with OUT_FRAC_BITS fraction bits.
// A missing word gives all zeros. The year feature saturates at the 16-bit limits.
// Config: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is the mean
// year (8 fraction bits), index 1 the inverse deviation (16 fraction bits).
// Other indexes are ignored. Write config only while the pipeline is empty.
// Throughput is one word per cycle while out_stall is low. From input accept to
// out_valid a word passes 11 stages of date conversion (bias, the reciprocal
// multiply and correction steps for the day, era, four-year and year divisions,
// day of year and month) plus lookup, year product and rounding stages.
// Stalls: out_stall holds the output register; upstream stages keep filling
// bubbles, and in_stall rises only when all 14 stages hold words.
// Reset (synchronous) empties the pipeline and sets mean 2000.0, inverse 1.0.
module timestamp_cyclic_feature_encoder import tcfe_pkg::*; #(
  parameter int OUT_FRAC_BITS = OutFracBits
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SecWidth-1:0] unix_seconds,
  input  logic                       is_missing,
  output logic                       out_valid,
  input  logic                       out_stall,
  output feat_t                      month_sine,
  output feat_t                      month_cosine,
  output feat_t                      day_sine,
  output feat_t                      day_cosine,
  output feat_t                      year_normalized,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CfgIndexWidth-1:0]   cfg_index,
  input  logic [CfgDataWidth-1:0]    cfg_data
);

  localparam int Stages = 3;
  localparam month_tab_t MonthSin = month_tab(OUT_FRAC_BITS, 1'b0);
  localparam month_tab_t MonthCos = month_tab(OUT_FRAC_BITS, 1'b1);
  localparam day_tab_t DaySin = day_tab(OUT_FRAC_BITS, 1'b0);
  localparam day_tab_t DayCos = day_tab(OUT_FRAC_BITS, 1'b1);
  // year product has YearFrac fraction bits
  localparam int YL = (OUT_FRAC_BITS > YearFrac) ? OUT_FRAC_BITS - YearFrac : 0;
  localparam int YR = (OUT_FRAC_BITS < YearFrac) ? YearFrac - OUT_FRAC_BITS : 0;
  localparam int YMagW = 50 + YL;
  localparam logic [YMagW-1:0] YHalf = YMagW'((YMagW'(1) << YR) >> 1);
  localparam logic [YMagW-1:0] PosMax = YMagW'(32767);
  localparam logic [YMagW-1:0] NegMax = YMagW'(32768);

  logic [MeanWidth-1:0]   year_mean;
  logic [InvStdWidth-1:0] year_inv_std;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_mean <= YearMeanReset;
      year_inv_std <= YearInvStdReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegYearMean:   year_mean <= cfg_data[MeanWidth-1:0];
        RegYearInvStd: year_inv_std <= cfg_data[InvStdWidth-1:0];
        default: ;
      endcase
    end
  end

  logic  civ_valid, civ_stall;
  date_t civ_date;

  tcfe_civil u_civil (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .unix_seconds (unix_seconds),
    .is_missing   (is_missing),
    .out_valid    (civ_valid),
    .out_stall    (civ_stall),
    .date         (civ_date)
  );

  logic [Stages-1:0] vld, vld_next, vld_in;
  logic [Stages:0]   open;
  logic [Stages-1:0] miss;

  assign open[Stages] = ~out_stall;
  for (genvar g = 0; g < Stages; g++) begin : g_open
    assign open[g] = ~vld[g] | open[g+1];
  end

  assign vld_in = {vld[Stages-2:0], civ_valid};
  assign vld_next = (open[Stages-1:0] & vld_in) | (~open[Stages-1:0] & vld);
  assign civ_stall = ~open[0];
  assign out_valid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  feat_t              f0_msin, f0_mcos, f0_dsin, f0_dcos;
  feat_t              f1_msin, f1_mcos, f1_dsin, f1_dcos;
  logic signed [24:0] f0_diff;
  logic signed [49:0] f1_prod;

  logic [24:0]      diff;
  logic [49:0]      mag;
  logic [YMagW-1:0] rnd;
  feat_t            ysat;

  always_comb begin
    diff = {civ_date.year[15], civ_date.year, 8'b0} - {3'b0, year_mean};
    mag = f1_prod[49] ? 50'(-f1_prod) : 50'(f1_prod);
    rnd = ((YMagW'(mag) << YL) + YHalf) >> YR;
    if (f1_prod[49]) begin
      ysat = (rnd >= NegMax) ? feat_t'(-32768) : feat_t'(-rnd[15:0]);
    end else begin
      ysat = (rnd > PosMax) ? feat_t'(32767) : feat_t'(rnd[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (open[0]) begin
      f0_msin <= MonthSin[civ_date.month];
      f0_mcos <= MonthCos[civ_date.month];
      f0_dsin <= DaySin[civ_date.day];
      f0_dcos <= DayCos[civ_date.day];
      f0_diff <= diff;
      miss[0] <= civ_date.missing;
    end
    if (open[1]) begin
      f1_prod <= f0_diff * $signed({1'b0, year_inv_std});
      f1_msin <= f0_msin;
      f1_mcos <= f0_mcos;
      f1_dsin <= f0_dsin;
      f1_dcos <= f0_dcos;
      miss[1] <= miss[0];
    end
    if (open[2]) begin
      month_sine <= miss[1] ? '0 : f1_msin;
      month_cosine <= miss[1] ? '0 : f1_mcos;
      day_sine <= miss[1] ? '0 : f1_dsin;
      day_cosine <= miss[1] ? '0 : f1_dcos;
      year_normalized <= miss[1] ? '0 : ysat;
      miss[2] <= miss[1];
    end
  end

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && civ_valid))
    else $error("input stalled with room in the pipeline");

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && miss[2]) |-> (month_sine == '0 && month_cosine == '0 &&
                                day_sine == '0 && day_cosine == '0 &&
                                year_normalized == '0))
    else $error("missing word gave nonzero features");
`endif

endmodule

@@ design/tcfe_civil.sv @@
// Pipelined conversion of Unix seconds to proleptic Gregorian year, month and day.
module tcfe_civil import tcfe_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SecWidth-1:0] unix_seconds,
  input  logic                       is_missing,
  output logic                       out_valid,
  input  logic                       out_stall,
  output date_t                      date
);

  localparam int Stages = 11;
  localparam longint EraBias = 17;
  localparam longint SecDiv = 675;
  // shift day zero so every date is nonnegative and starts on a 400-year era
  localparam longint DayBias = 64'd719468 + 64'd146097 * EraBias;
  localparam logic [32:0] SecBias = 33'(SecDiv * DayBias);
  localparam logic [23:0] SecRecip = 24'(64'h2_0000_0000 / SecDiv);
  localparam logic [10:0] SecDiv11 = 11'(SecDiv);
  localparam logic [5:0]  EraRecip = 6'd57;
  localparam logic [18:0] EraDays19 = 19'd146097;
  localparam logic [7:0]  Rec1460 = 8'd179;
  localparam logic [11:0] Div1460 = 12'd1460;
  localparam logic [9:0]  Rec365 = 10'd718;
  localparam logic [9:0]  Div365 = 10'd365;
  localparam logic [15:0] YearBias = 16'(EraBias * 400);
  localparam logic [8:0]  MonthStart [12] = '{9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
                                             9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337};

  logic [Stages-1:0] vld, vld_next, vld_in;
  logic [Stages:0]   open;
  logic [Stages-1:0] miss;

  assign open[Stages] = ~out_stall;
  for (genvar g = 0; g < Stages; g++) begin : g_open
    assign open[g] = ~vld[g] | open[g+1];
  end

  assign vld_in = {vld[Stages-2:0], in_valid};
  assign vld_next = (open[Stages-1:0] & vld_in) | (~open[Stages-1:0] & vld);
  assign in_stall = ~open[0];
  assign out_valid = vld[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  // stage payloads
  logic [32:0] s1_v, s2_v;
  logic [22:0] s2_q, s3_z, s4_z;
  logic [5:0]  s4_era, s5_era, s6_era, s7_era, s8_era, s9_era, s10_era;
  logic [17:0] s5_doe, s6_doe, s7_doe, s8_doe, s9_doe;
  logic [6:0]  s6_a;
  logic [2:0]  s6_b;
  logic        s6_c;
  logic [17:0] s7_n, s8_n;
  logic [8:0]  s8_y, s9_yoe, s10_yoe;
  logic [8:0]  s10_doy;
  year_t       s11_year;
  logic [3:0]  s11_month;
  logic [4:0]  s11_day;

  logic [33:0] v1;
  logic [56:0] p2;
  logic [10:0] r3;
  logic [28:0] p4;
  logic [18:0] r5;
  logic        geq5;
  logic [25:0] p6;
  logic [2:0]  b6;
  logic [11:0] ra7;
  logic [6:0]  a7;
  logic [27:0] p8;
  logic [9:0]  ry9;
  logic [1:0]  cent10;
  logic [17:0] doy10;
  logic [3:0]  mp11;

  always_comb begin
    // floor(t / 128) is the top bits; bias makes it nonnegative
    v1 = {{2{unix_seconds[SecWidth-1]}}, unix_seconds[SecWidth-1:7]} + {1'b0, SecBias};
    p2 = 57'(s1_v) * 57'(SecRecip);
    // remainder below 2*675, so low bits are enough
    r3 = s2_v[10:0] - s2_q[10:0] * SecDiv11;
    p4 = 29'(s3_z) * 29'(EraRecip);
    r5 = s4_z[18:0] - 19'(s4_era) * EraDays19;
    geq5 = (r5 >= EraDays19);
    p6 = 26'(s5_doe) * 26'(Rec1460);
    b6 = 3'(s5_doe >= 18'd36524) + 3'(s5_doe >= 18'd73048)
       + 3'(s5_doe >= 18'd109572) + 3'(s5_doe >= 18'd146096);
    ra7 = s6_doe[11:0] - 12'(s6_a) * Div1460;
    a7 = s6_a + 7'(ra7 >= Div1460);
    p8 = 28'(s7_n) * 28'(Rec365);
    ry9 = s8_n[9:0] - 10'(s8_y) * Div365;
    cent10 = 2'(s9_yoe >= 9'd100) + 2'(s9_yoe >= 9'd200) + 2'(s9_yoe >= 9'd300);
    doy10 = s9_doe - (18'(s9_yoe) * 18'd365 + 18'(s9_yoe >> 2) - 18'(cent10));
    // month index counted from March
    mp11 = 4'd0;
    for (int j = 1; j < 12; j++) begin
      if (s10_doy >= MonthStart[j]) mp11 = 4'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (open[0]) begin
      s1_v <= v1[32:0];
      miss[0] <= is_missing;
    end
    for (int i = 1; i < Stages; i++) begin
      if (open[i]) miss[i] <= miss[i-1];
    end
    if (open[1]) begin
      s2_q <= p2[55:33];
      s2_v <= s1_v;
    end
    if (open[2]) begin
      s3_z <= s2_q + 23'(r3 >= SecDiv11);
    end
    if (open[3]) begin
      s4_era <= p4[28:23];
      s4_z <= s3_z;
    end
    if (open[4]) begin
      s5_era <= s4_era + 6'(geq5);
      s5_doe <= geq5 ? 18'(r5 - EraDays19) : 18'(r5);
    end
    if (open[5]) begin
      s6_a <= p6[24:18];
      s6_b <= b6;
      s6_c <= (s5_doe == 18'd146096);
      s6_doe <= s5_doe;
      s6_era <= s5_era;
    end
    if (open[6]) begin
      s7_n <= s6_doe - 18'(a7) + 18'(s6_b) - 18'(s6_c);
      s7_doe <= s6_doe;
      s7_era <= s6_era;
    end
    if (open[7]) begin
      s8_y <= p8[26:18];
      s8_n <= s7_n;
      s8_doe <= s7_doe;
      s8_era <= s7_era;
    end
    if (open[8]) begin
      s9_yoe <= s8_y + 9'(ry9 >= Div365);
      s9_doe <= s8_doe;
      s9_era <= s8_era;
    end
    if (open[9]) begin
      s10_doy <= doy10[8:0];
      s10_yoe <= s9_yoe;
      s10_era <= s9_era;
    end
    if (open[10]) begin
      s11_day <= 5'(s10_doy - MonthStart[mp11] + 9'd1);
      s11_month <= (mp11 < 4'd10) ? mp11 + 4'd3 : mp11 - 4'd9;
      // January and February belong to the following year
      s11_year <= year_t'(16'(s10_yoe) + 16'(s10_era) * 16'd400 - YearBias
                          + 16'(mp11 >= 4'd10));
    end
  end

  assign date = '{year: s11_year, month: s11_month, day: s11_day, missing: miss[Stages-1]};

`ifndef SYNTH
  a_doe_range: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (19'(s5_doe) < EraDays19))
    else $error("day of era out of range");

  a_yoe_range: assert property (@(posedge clk) disable iff (rst)
    vld[8] |-> (s9_yoe < 9'd400))
    else $error("year of era out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (date.month >= 4'd1 && date.month <= 4'd12 &&
                   date.day >= 5'd1 && date.day <= 5'd31))
    else $error("civil date out of range");
`endif

endmodule
